// ===== rtl/core/vls_pkg.sv =====
// Shared types and constants of the load/store unit: request and response
// structs, status and operation codes, address map and the state encoding.
// Depends on nothing; every other file of the unit but vls_ram uses it.
package vls_pkg;

  // Default size of the byte memory and the width of a memory byte address
  localparam int unsigned MEM_BYTES = 2048;
  localparam int unsigned MEM_ADDR_W = 16;

  // Address map
  localparam logic [31:0] CONS_CHAR_ADDR = 32'h0000_0812;
  localparam logic [31:0] CONS_INT_ADDR  = 32'h0000_0816;
  localparam logic [31:0] HEAP_LO_ADDR   = 32'h0000_B700;
  localparam logic [31:0] HEAP_HI_ADDR   = 32'h0000_D700;
  localparam logic [31:0] VR_LO_ADDR     = 32'h0000_0800;
  localparam logic [31:0] VR_HI_ADDR     = 32'h0000_0834;
  localparam logic [31:0] STORE_LO_ADDR  = 32'd1024;

  // Low byte of each virtual routine address (the span sits at 0x08xx)
  localparam logic [7:0] VR_CHAR  = 8'h00;
  localparam logic [7:0] VR_DEC   = 8'h04;
  localparam logic [7:0] VR_HEX   = 8'h08;
  localparam logic [7:0] VR_HALT  = 8'h0C;
  localparam logic [7:0] VR_PC    = 8'h20;
  localparam logic [7:0] VR_REGS  = 8'h24;
  localparam logic [7:0] VR_DUMP  = 8'h28;
  localparam logic [7:0] VR_ALLOC = 8'h30;
  localparam logic [7:0] VR_FREE  = 8'h34;

  typedef enum logic [3:0] {
    OP_LB    = 4'd0,
    OP_LH    = 4'd1,
    OP_LW    = 4'd2,
    OP_LBU   = 4'd3,
    OP_LHU   = 4'd4,
    OP_SB    = 4'd5,
    OP_SH    = 4'd6,
    OP_SW    = 4'd7,
    OP_IMAGE = 4'd8
  } op_e;

  typedef enum logic [3:0] {
    ST_LOAD     = 4'd0,
    ST_STORE    = 4'd1,
    ST_ILLEGAL  = 4'd2,
    ST_CHAR     = 4'd3,
    ST_DEC      = 4'd4,
    ST_HEX      = 4'd5,
    ST_HALT     = 4'd6,
    ST_PC_DUMP  = 4'd7,
    ST_REG_DUMP = 4'd8,
    ST_MEM_DUMP = 4'd9,
    ST_ALLOC    = 4'd10,
    ST_FREE     = 4'd11,
    ST_HEAP     = 4'd12,
    ST_CONSOLE  = 4'd13,
    ST_NONE     = 4'd14
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_READ
  } fsm_e;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] base;
    logic signed [11:0] offset;
    logic signed [31:0] store_data;
    logic signed [31:0] console_value;
    logic [4:0]         dest_index;
  } vls_req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] load_value;
    logic               write_reg;
    logic [4:0]         dest_out;
    logic signed [31:0] out_value;
    logic [15:0]        forward_address;
  } vls_rsp_t;

  // Byte memory access: nbytes is 1, 2 or 4
  typedef struct packed {
    logic                  rd;
    logic                  wr;
    logic [MEM_ADDR_W-1:0] addr;
    logic [2:0]            nbytes;
    logic [31:0]           wdata;
  } vls_mem_req_t;

  // Decoded request: the response so far and the memory access it needs
  typedef struct packed {
    vls_rsp_t     rsp;
    vls_mem_req_t mem;
    logic         rd_unsigned;
    logic         rd_dump;
  } vls_act_t;

endpackage

// ===== rtl/core/vm_load_store_unit.sv =====
// Top level of the load/store unit: request register, sequencer, byte
// memory and response register. Depends on vls_pkg, vls_decode, vls_mem_port.
//
//   channel   direction  handshake                 payload
//   request   in         in_valid_i / in_ready_o   in_req_i  (vls_req_t)
//   response  out        out_valid_o / out_ready_i out_rsp_o (vls_rsp_t)
//
// An accepted request forms its address in the accept cycle and is decoded in
// the next. Requests without a memory read finish in EXEC; loads and memory
// dumps go on to READ for the registered bank read data. One request is
// in flight; the next is taken once the last sits in the response register.
// A stalled response holds the unit in its last step; stores write on leaving it.
// Reset clears control only; the byte memory is undefined until written.
module vm_load_store_unit #(
  parameter int unsigned MemBytes = vls_pkg::MEM_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vls_pkg::vls_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vls_pkg::vls_rsp_t out_rsp_o
);

  vls_pkg::fsm_e         state_q, state_d;
  logic [3:0]            op_q;
  logic [31:0]           addr_q;
  logic [31:0]           data_q;
  logic [31:0]           cons_q;
  logic [4:0]            dest_q;
  vls_pkg::vls_act_t     act;
  vls_pkg::vls_act_t     act_q;
  vls_pkg::vls_mem_req_t mem_req;
  logic [31:0]           rword;
  logic                  out_free;
  logic                  rsp_load;
  logic                  out_valid_q;
  vls_pkg::vls_rsp_t     rsp_q, rsp_d;

  // Take a request and form its effective address
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= in_req_i.op;
      addr_q <= in_req_i.base + {{20{in_req_i.offset[11]}}, in_req_i.offset};
      data_q <= in_req_i.store_data;
      cons_q <= in_req_i.console_value;
      dest_q <= in_req_i.dest_index;
    end
  end

  vls_decode #(
    .MemBytes(MemBytes)
  ) u_decode (
    .op_i  (op_q),
    .addr_i(addr_q),
    .data_i(data_q),
    .cons_i(cons_q),
    .dest_i(dest_q),
    .act_o (act)
  );

  // Hold the decoded request while the read is under way
  always_ff @(posedge clk_i) begin
    if (state_q == vls_pkg::FSM_EXEC) begin
      act_q <= act;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vls_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = vls_pkg::FSM_EXEC;
        end
      end
      vls_pkg::FSM_EXEC: begin
        if (act.mem.rd) begin
          state_d = vls_pkg::FSM_READ;
        end else if (out_free) begin
          state_d = vls_pkg::FSM_IDLE;
        end
      end
      vls_pkg::FSM_READ: begin
        if (out_free) begin
          state_d = vls_pkg::FSM_IDLE;
        end
      end
      default: state_d = vls_pkg::FSM_IDLE;
    endcase
  end

  // Sequencer outputs: request ready, memory strobes, response load
  always_comb begin
    in_ready_o = 1'b0;
    mem_req    = act.mem;
    mem_req.rd = 1'b0;
    mem_req.wr = 1'b0;
    rsp_load   = 1'b0;
    unique case (state_q)
      vls_pkg::FSM_IDLE: in_ready_o = 1'b1;
      vls_pkg::FSM_EXEC: begin
        mem_req.rd = act.mem.rd;
        mem_req.wr = act.mem.wr && out_free;
        rsp_load   = !act.mem.rd && out_free;
      end
      vls_pkg::FSM_READ: rsp_load = out_free;
      default: ;
    endcase
  end

  vls_mem_port #(
    .MemBytes(MemBytes)
  ) u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(rword)
  );

  // Response: straight from decode, or with the read data (extended for a load, raw for a dump)
  always_comb begin
    if (state_q == vls_pkg::FSM_READ) begin
      rsp_d = act_q.rsp;
      if (act_q.rd_dump) begin
        rsp_d.out_value = rword;
      end else begin
        unique case (act_q.mem.nbytes)
          3'd1:    rsp_d.load_value = act_q.rd_unsigned ? {24'd0, rword[7:0]}
                                                        : {{24{rword[7]}}, rword[7:0]};
          3'd2:    rsp_d.load_value = act_q.rd_unsigned ? {16'd0, rword[15:0]}
                                                        : {{16{rword[15]}}, rword[15:0]};
          default: rsp_d.load_value = rword;
        endcase
      end
    end else begin
      rsp_d = act.rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vls_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== rtl/core/vls_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing.
module vls_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, or read into the read register; the read data holds otherwise
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/vls_decode.sv =====
// Address decode of one registered request: region checks, console and
// virtual routine addresses, heap window and the byte memory access.
// Depends on vls_pkg.
module vls_decode #(
  parameter int unsigned MemBytes = vls_pkg::MEM_BYTES
) (
  input  logic [3:0]         op_i,
  input  logic [31:0]        addr_i,
  input  logic [31:0]        data_i,
  input  logic [31:0]        cons_i,
  input  logic [4:0]         dest_i,
  output vls_pkg::vls_act_t  act_o
);

  localparam logic [31:0] Lim1 = 32'(MemBytes - 1);
  localparam logic [31:0] Lim2 = 32'(MemBytes - 2);
  localparam logic [31:0] Lim4 = 32'(MemBytes - 4);

  logic        neg;
  logic        heap;
  logic        fits;
  logic        vr_span;
  logic [2:0]  nbytes;
  logic        dump_fits;

  // Region flags
  always_comb begin
    neg       = addr_i[31];
    heap      = !neg && (addr_i >= vls_pkg::HEAP_LO_ADDR) && (addr_i <= vls_pkg::HEAP_HI_ADDR);
    vr_span   = (addr_i >= vls_pkg::VR_LO_ADDR) && (addr_i <= vls_pkg::VR_HI_ADDR);
    dump_fits = (data_i <= Lim4);
    unique case (vls_pkg::op_e'(op_i))
      vls_pkg::OP_LH, vls_pkg::OP_LHU, vls_pkg::OP_SH: nbytes = 3'd2;
      vls_pkg::OP_LW, vls_pkg::OP_SW:                  nbytes = 3'd4;
      default:                                         nbytes = 3'd1;
    endcase
    unique case (nbytes)
      3'd2:    fits = (addr_i <= Lim2);
      3'd4:    fits = (addr_i <= Lim4);
      default: fits = (addr_i <= Lim1);
    endcase
  end

  // Decide status, result fields and the memory access
  always_comb begin
    act_o                     = '0;
    act_o.rsp.status          = vls_pkg::ST_NONE;
    act_o.rsp.dest_out        = dest_i;
    act_o.mem.addr            = addr_i[vls_pkg::MEM_ADDR_W-1:0];
    act_o.mem.nbytes          = nbytes;
    act_o.mem.wdata           = data_i;
    act_o.rd_unsigned         = 1'b0;
    unique case (vls_pkg::op_e'(op_i))
      vls_pkg::OP_LB, vls_pkg::OP_LH, vls_pkg::OP_LW,
      vls_pkg::OP_LBU, vls_pkg::OP_LHU: begin
        act_o.rd_unsigned = (vls_pkg::op_e'(op_i) == vls_pkg::OP_LBU) ||
                            (vls_pkg::op_e'(op_i) == vls_pkg::OP_LHU);
        if (neg) begin
          act_o.rsp.status = vls_pkg::ST_ILLEGAL;
        end else if (addr_i == vls_pkg::CONS_CHAR_ADDR) begin
          act_o.rsp.status     = vls_pkg::ST_CONSOLE;
          act_o.rsp.load_value = {{24{cons_i[7]}}, cons_i[7:0]};
          act_o.rsp.write_reg  = 1'b1;
        end else if (addr_i == vls_pkg::CONS_INT_ADDR) begin
          act_o.rsp.status     = vls_pkg::ST_CONSOLE;
          act_o.rsp.load_value = cons_i;
          act_o.rsp.write_reg  = 1'b1;
        end else if (heap) begin
          act_o.rsp.status          = vls_pkg::ST_HEAP;
          act_o.rsp.forward_address = addr_i[15:0];
        end else if (!fits) begin
          act_o.rsp.status = vls_pkg::ST_ILLEGAL;
        end else begin
          act_o.rsp.status    = vls_pkg::ST_LOAD;
          act_o.rsp.write_reg = 1'b1;
          act_o.mem.rd        = 1'b1;
        end
      end
      vls_pkg::OP_SB, vls_pkg::OP_SH, vls_pkg::OP_SW: begin
        if (neg || (addr_i < vls_pkg::STORE_LO_ADDR)) begin
          act_o.rsp.status = vls_pkg::ST_ILLEGAL;
        end else if (vr_span) begin
          unique case (addr_i[7:0])
            vls_pkg::VR_CHAR: begin
              act_o.rsp.status    = vls_pkg::ST_CHAR;
              act_o.rsp.out_value = data_i;
            end
            vls_pkg::VR_DEC: begin
              act_o.rsp.status    = vls_pkg::ST_DEC;
              act_o.rsp.out_value = data_i;
            end
            vls_pkg::VR_HEX: begin
              act_o.rsp.status    = vls_pkg::ST_HEX;
              act_o.rsp.out_value = data_i;
            end
            vls_pkg::VR_HALT: act_o.rsp.status = vls_pkg::ST_HALT;
            vls_pkg::VR_PC:   act_o.rsp.status = vls_pkg::ST_PC_DUMP;
            vls_pkg::VR_REGS: act_o.rsp.status = vls_pkg::ST_REG_DUMP;
            vls_pkg::VR_DUMP: begin
              if (dump_fits) begin
                act_o.rsp.status = vls_pkg::ST_MEM_DUMP;
                act_o.mem.rd     = 1'b1;
                act_o.mem.addr   = data_i[vls_pkg::MEM_ADDR_W-1:0];
                act_o.mem.nbytes = 3'd4;
                act_o.rd_dump    = 1'b1;
              end else begin
                act_o.rsp.status = vls_pkg::ST_ILLEGAL;
              end
            end
            vls_pkg::VR_ALLOC: begin
              act_o.rsp.status    = vls_pkg::ST_ALLOC;
              act_o.rsp.out_value = data_i;
            end
            vls_pkg::VR_FREE: begin
              act_o.rsp.status    = vls_pkg::ST_FREE;
              act_o.rsp.out_value = data_i;
            end
            default: act_o.rsp.status = vls_pkg::ST_NONE;
          endcase
        end else if (heap) begin
          act_o.rsp.status          = vls_pkg::ST_HEAP;
          act_o.rsp.forward_address = addr_i[15:0];
          act_o.rsp.out_value       = data_i;
        end else if (!fits) begin
          act_o.rsp.status = vls_pkg::ST_ILLEGAL;
        end else begin
          act_o.rsp.status = vls_pkg::ST_STORE;
          act_o.mem.wr     = 1'b1;
        end
      end
      vls_pkg::OP_IMAGE: begin
        // Image byte write: no region decode, only the memory bound
        if (!neg && fits) begin
          act_o.rsp.status = vls_pkg::ST_STORE;
          act_o.mem.wr     = 1'b1;
        end else begin
          act_o.rsp.status = vls_pkg::ST_ILLEGAL;
        end
      end
      default: act_o.rsp.status = vls_pkg::ST_NONE;
    endcase
  end

endmodule

// ===== rtl/core/vls_mem_port.sv =====
// Byte memory as four byte-wide banks, one per address lane, so that an
// unaligned access of up to four bytes touches each bank once.
// Depends on vls_pkg and vls_ram.
module vls_mem_port #(
  parameter int unsigned MemBytes = vls_pkg::MEM_BYTES
) (
  input  logic                  clk_i,
  input  vls_pkg::vls_mem_req_t req_i,
  output logic [31:0]           rdata_o
);

  localparam int unsigned BankDepth = (MemBytes + 3) / 4;
  localparam int unsigned RowW = $clog2(BankDepth);
  localparam int unsigned RowBaseW = vls_pkg::MEM_ADDR_W - 2;

  logic [1:0]          lane;
  logic [1:0]          lane_q;
  logic [RowBaseW-1:0] row_base;
  logic [7:0]          rbyte [4];

  assign lane     = req_i.addr[1:0];
  assign row_base = req_i.addr[vls_pkg::MEM_ADDR_W-1:2];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]          k;
    logic                active;
    logic [RowBaseW-1:0] row;
    logic [7:0]          wbyte;

    // Steer byte k of the access into this bank, one row on when it wraps
    always_comb begin
      k      = 2'(b) - lane;
      active = ({1'b0, k} < req_i.nbytes);
      row    = row_base + RowBaseW'(2'(b) < lane);
      wbyte  = req_i.wdata[{k, 3'b000} +: 8];
    end

    vls_ram #(
      .Width(8),
      .Depth(BankDepth)
    ) u_bank (
      .clk_i  (clk_i),
      .en_i   ((req_i.rd || req_i.wr) && active),
      .we_i   (req_i.wr),
      .addr_i (row[RowW-1:0]),
      .wdata_i(wbyte),
      .rdata_o(rbyte[b])
    );
  end

  // Hold the start lane for the read reassembly
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      lane_q <= lane;
    end
  end

  // Reassemble little-endian: byte i comes from lane start + i
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[8*i +: 8] = rbyte[2'(lane_q + 2'(i))];
    end
  end

endmodule

// ===== rtl/core/vls_checker.sv =====
// Port-level checks of the load/store unit, attached by bind.
// Depends on vls_pkg and vm_load_store_unit.
module vls_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input vls_pkg::vls_rsp_t out_rsp_o
);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // Take no new request right after one was accepted
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while one is in flight");

  // Write the register only for a load or a console read
  a_write_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.write_reg |->
      out_rsp_o.status == vls_pkg::ST_LOAD || out_rsp_o.status == vls_pkg::ST_CONSOLE)
    else $error("register write on a non-load response");

  // Drive the heap address only on a heap forward
  a_fwd_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != vls_pkg::ST_HEAP |->
      out_rsp_o.forward_address == 16'd0)
    else $error("forward address outside a heap forward");

  // Drop all data on an illegal access
  a_illegal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == vls_pkg::ST_ILLEGAL |->
      !out_rsp_o.write_reg && out_rsp_o.load_value == 32'sd0 &&
      out_rsp_o.out_value == 32'sd0)
    else $error("illegal access carries data");

endmodule

bind vm_load_store_unit vls_checker u_vls_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);

// ===== tb/vm_load_store_unit_tb.sv =====
// Self-checking testbench of the load/store unit: directed and random accesses
// checked against a behavioural prediction of address decode and byte memory.
// Depends on vls_pkg and vm_load_store_unit.
module vm_load_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vls_pkg::*;

  localparam int unsigned MEM_SIZE = vls_pkg::MEM_BYTES;
  localparam logic [31:0] DUMP_ADDR = {VR_LO_ADDR[31:8], VR_DUMP};
  localparam logic [31:0] VR_UNUSED_ADDR = VR_LO_ADDR + 32'h10;
  localparam logic [3:0] OP_RESERVED_LO = 4'd9;
  localparam logic [3:0] OP_RESERVED_HI = 4'd15;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  vls_req_t in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  vls_rsp_t out_rsp_o;

  // Predicted byte memory and which bytes hold a defined value
  logic [7:0] mem_image [MEM_SIZE];
  bit         mem_valid [MEM_SIZE];

  vls_rsp_t    expected_rsp_q [$];
  vls_rsp_t    expected_rsp;
  int unsigned mismatch_count = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  vm_load_store_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bit in_memory(input logic [31:0] a, input int unsigned n);
    return (64'(a) + 64'(n)) <= 64'(MEM_SIZE);
  endfunction

  function automatic int unsigned access_bytes(input logic [3:0] op);
    case (op)
      OP_LW, OP_SW: return 4;
      OP_LH, OP_LHU, OP_SH: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic bit bytes_written(input logic [31:0] a, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (!mem_valid[a + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] read_bytes(input logic [31:0] a, input int unsigned n);
    logic [31:0] w;
    w = '0;
    for (int unsigned i = 0; i < n; i++) w[8*i +: 8] = mem_image[a + i];
    return w;
  endfunction

  function automatic void write_bytes(input logic [31:0] a, input int unsigned n,
                                      input logic [31:0] d);
    for (int unsigned i = 0; i < n; i++) begin
      mem_image[a + i] = d[8*i +: 8];
      mem_valid[a + i] = 1'b1;
    end
  endfunction

  // Work out the response of one request and apply its store to the memory image
  function automatic vls_rsp_t predict_access(input vls_req_t r);
    vls_rsp_t    rsp;
    logic [31:0] addr;
    logic [31:0] data;
    logic [31:0] word;
    int unsigned nbytes;
    bit          neg;
    bit          heap;
    addr   = r.base + {{20{r.offset[11]}}, r.offset};
    data   = r.store_data;
    neg    = addr[31];
    heap   = !neg && addr >= HEAP_LO_ADDR && addr <= HEAP_HI_ADDR;
    nbytes = access_bytes(r.op);
    rsp = '0;
    rsp.status   = ST_NONE;
    rsp.dest_out = r.dest_index;
    if (r.op <= OP_LHU) begin
      if (neg) begin
        rsp.status = ST_ILLEGAL;
      end else if (addr == CONS_CHAR_ADDR) begin
        rsp.status     = ST_CONSOLE;
        rsp.load_value = {{24{r.console_value[7]}}, r.console_value[7:0]};
        rsp.write_reg  = 1'b1;
      end else if (addr == CONS_INT_ADDR) begin
        rsp.status     = ST_CONSOLE;
        rsp.load_value = r.console_value;
        rsp.write_reg  = 1'b1;
      end else if (heap) begin
        rsp.status          = ST_HEAP;
        rsp.forward_address = addr[15:0];
      end else if (!in_memory(addr, nbytes)) begin
        rsp.status = ST_ILLEGAL;
      end else begin
        word = read_bytes(addr, nbytes);
        case (r.op)
          OP_LB: rsp.load_value = {{24{word[7]}}, word[7:0]};
          OP_LH: rsp.load_value = {{16{word[15]}}, word[15:0]};
          default: rsp.load_value = word;
        endcase
        rsp.status    = ST_LOAD;
        rsp.write_reg = 1'b1;
      end
    end else if (r.op <= OP_SW) begin
      if (neg || addr < STORE_LO_ADDR) begin
        rsp.status = ST_ILLEGAL;
      end else if (addr >= VR_LO_ADDR && addr <= VR_HI_ADDR) begin
        case (addr[7:0])
          VR_CHAR: begin rsp.status = ST_CHAR;  rsp.out_value = data; end
          VR_DEC: begin rsp.status = ST_DEC;   rsp.out_value = data; end
          VR_HEX: begin rsp.status = ST_HEX;   rsp.out_value = data; end
          VR_HALT: rsp.status = ST_HALT;
          VR_PC: rsp.status = ST_PC_DUMP;
          VR_REGS: rsp.status = ST_REG_DUMP;
          VR_DUMP: begin
            if (in_memory(data, 4)) begin
              rsp.status    = ST_MEM_DUMP;
              rsp.out_value = read_bytes(data, 4);
            end else begin
              rsp.status = ST_ILLEGAL;
            end
          end
          VR_ALLOC: begin rsp.status = ST_ALLOC; rsp.out_value = data; end
          VR_FREE: begin rsp.status = ST_FREE;  rsp.out_value = data; end
          default: rsp.status = ST_NONE;
        endcase
      end else if (heap) begin
        rsp.status          = ST_HEAP;
        rsp.forward_address = addr[15:0];
        rsp.out_value       = data;
      end else if (!in_memory(addr, nbytes)) begin
        rsp.status = ST_ILLEGAL;
      end else begin
        write_bytes(addr, nbytes, data);
        rsp.status = ST_STORE;
      end
    end else if (r.op == OP_IMAGE) begin
      if (!neg && in_memory(addr, 1)) begin
        write_bytes(addr, 1, data);
        rsp.status = ST_STORE;
      end else begin
        rsp.status = ST_ILLEGAL;
      end
    end
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Request building
  // ---------------------------------------------------------------------------

  // Split a target address into base and offset, randomise the rest
  function automatic vls_req_t build_request(input logic [3:0] op, input logic [31:0] addr);
    vls_req_t    r;
    logic [11:0] off;
    case ($urandom_range(9))
      0: off = 12'h800;
      1: off = 12'h7FF;
      default: off = 12'($urandom());
    endcase
    r.op            = op;
    r.offset        = off;
    r.base          = addr - {{20{off[11]}}, off};
    r.store_data    = $urandom();
    r.console_value = $urandom();
    r.dest_index    = 5'($urandom());
    return r;
  endfunction

  // Favour a small window above lo and the top of memory
  function automatic logic [31:0] pick_mem_addr(input logic [31:0] lo);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return lo + $urandom_range(63);
      5, 6: return MEM_SIZE - 1 - $urandom_range(7);
      default: return $urandom_range(MEM_SIZE - 1, lo);
    endcase
  endfunction

  function automatic logic [31:0] routine_addr(input int unsigned slot);
    case (slot)
      0: return {VR_LO_ADDR[31:8], VR_CHAR};
      1: return {VR_LO_ADDR[31:8], VR_DEC};
      2: return {VR_LO_ADDR[31:8], VR_HEX};
      3: return {VR_LO_ADDR[31:8], VR_HALT};
      4: return {VR_LO_ADDR[31:8], VR_PC};
      5: return {VR_LO_ADDR[31:8], VR_REGS};
      6: return DUMP_ADDR;
      7: return {VR_LO_ADDR[31:8], VR_ALLOC};
      8: return {VR_LO_ADDR[31:8], VR_FREE};
      default: return $urandom_range(VR_HI_ADDR, VR_LO_ADDR);
    endcase
  endfunction

  // Dump source: a fully written word, or one that does not fit in memory
  function automatic logic [31:0] dump_source();
    logic [31:0] a;
    a = pick_mem_addr(0);
    if ($urandom_range(3) != 0 && in_memory(a, 4) && bytes_written(a, 4)) return a;
    if ($urandom_range(1) != 0) return MEM_SIZE - 3 + $urandom_range(2);
    return $urandom() | MEM_SIZE;
  endfunction

  // ---------------------------------------------------------------------------
  // Request channel: hold the request until taken, then predict its response
  // ---------------------------------------------------------------------------

  task automatic issue_access(input vls_req_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsp_q.push_back(predict_access(req));
  endtask

  // Response channel: stall at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // Compare each response with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: response with nothing outstanding, status=%0d", $time,
                   out_rsp_o.status);
        mismatch_count++;
      end else begin
        expected_rsp = expected_rsp_q.pop_front();
        if (out_rsp_o.status !== expected_rsp.status ||
            out_rsp_o.load_value !== expected_rsp.load_value ||
            out_rsp_o.write_reg !== expected_rsp.write_reg ||
            out_rsp_o.dest_out !== expected_rsp.dest_out ||
            out_rsp_o.out_value !== expected_rsp.out_value ||
            out_rsp_o.forward_address !== expected_rsp.forward_address) begin
          if (mismatch_count < 10) begin
            $display("%0t: mismatch exp st=%0d lv=%h wr=%b rd=%0d ov=%h fa=%h", $time,
                     expected_rsp.status, expected_rsp.load_value, expected_rsp.write_reg,
                     expected_rsp.dest_out, expected_rsp.out_value,
                     expected_rsp.forward_address);
            $display("%0t: mismatch got st=%0d lv=%h wr=%b rd=%0d ov=%h fa=%h", $time,
                     out_rsp_o.status, out_rsp_o.load_value, out_rsp_o.write_reg,
                     out_rsp_o.dest_out, out_rsp_o.out_value, out_rsp_o.forward_address);
          end
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Word store, then narrower loads of its bytes; halfword straddling the end
  task automatic test_memory_access();
    vls_req_t r;
    r = build_request(OP_SW, STORE_LO_ADDR);
    r.store_data = 32'h8001_FF80;
    issue_access(r);
    issue_access(build_request(OP_LB, STORE_LO_ADDR));
    issue_access(build_request(OP_LH, STORE_LO_ADDR));
    issue_access(build_request(OP_LHU, STORE_LO_ADDR + 2));
    issue_access(build_request(OP_LBU, STORE_LO_ADDR + 3));
    issue_access(build_request(OP_SH, MEM_SIZE - 1));
  endtask

  // Image byte at the bottom of memory, and just past the top
  task automatic test_image_writes();
    issue_access(build_request(OP_IMAGE, 32'h0));
    issue_access(build_request(OP_IMAGE, MEM_SIZE));
  endtask

  // Char read with a negative byte, integer read with the sign bit set
  task automatic test_console_reads();
    vls_req_t r;
    r = build_request(OP_LHU, CONS_CHAR_ADDR);
    r.console_value = 32'h0000_0080;
    issue_access(r);
    r = build_request(OP_LW, CONS_INT_ADDR);
    r.console_value = 32'h8000_0000;
    issue_access(r);
  endtask

  // Every routine slot, an unused slot and a dump source outside memory
  task automatic test_virtual_routines();
    vls_req_t r;
    for (int unsigned k = 0; k < 9; k++) begin
      r = build_request(4'($urandom_range(OP_SW, OP_SB)), routine_addr(k));
      if (k == 6) r.store_data = STORE_LO_ADDR;
      issue_access(r);
    end
    issue_access(build_request(OP_SW, VR_UNUSED_ADDR));
    r = build_request(OP_SB, DUMP_ADDR);
    r.store_data = 32'hFFFF_FFFF;
    issue_access(r);
  endtask

  // Both edges of the heap window
  task automatic test_heap_window();
    issue_access(build_request(OP_LW, HEAP_LO_ADDR));
    issue_access(build_request(OP_SW, HEAP_HI_ADDR));
  endtask

  // Address wrapping negative, store below the store region, reserved opcode
  task automatic test_illegal_addresses();
    vls_req_t r;
    r = build_request(OP_LW, 32'h0);
    r.base   = 32'h7FFF_FFFF;
    r.offset = 12'h001;
    issue_access(r);
    issue_access(build_request(OP_SB, STORE_LO_ADDR - 1));
    issue_access(build_request(OP_RESERVED_HI, $urandom()));
  endtask

  // Mostly stores followed by loads of what they wrote, plus decode corners
  task automatic test_random_mix(input int unsigned count);
    vls_req_t    r;
    logic [3:0]  op;
    logic [31:0] addr;
    int unsigned pick;
    int unsigned nbytes;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        op = 4'($urandom_range(OP_SW, OP_SB));
        r  = build_request(op, pick_mem_addr(STORE_LO_ADDR));
      end else if (pick < 36) begin
        addr = ($urandom_range(9) == 0) ? MEM_SIZE + $urandom_range(15) : pick_mem_addr(0);
        r = build_request(OP_IMAGE, addr);
      end else if (pick < 64) begin
        op     = 4'($urandom_range(OP_LHU, OP_LB));
        addr   = pick_mem_addr($urandom_range(1) ? 32'h0 : STORE_LO_ADDR);
        nbytes = access_bytes(op);
        // Fill an unwritten spot instead of reading it
        if (in_memory(addr, nbytes) && !bytes_written(addr, nbytes)) begin
          if (addr >= STORE_LO_ADDR) begin
            op = (nbytes == 4) ? OP_SW : (nbytes == 2) ? OP_SH : OP_SB;
          end else begin
            op = OP_IMAGE;
            while (mem_valid[addr]) addr++;
          end
        end
        r = build_request(op, addr);
      end else if (pick < 69) begin
        op = 4'($urandom_range(OP_LHU, OP_LB));
        r  = build_request(op, $urandom_range(1) ? CONS_CHAR_ADDR : CONS_INT_ADDR);
      end else if (pick < 80) begin
        addr = routine_addr($urandom_range(9));
        r    = build_request(4'($urandom_range(OP_SW, OP_SB)), addr);
        if (addr == DUMP_ADDR) r.store_data = dump_source();
      end else if (pick < 87) begin
        case ($urandom_range(3))
          0: addr = HEAP_LO_ADDR;
          1: addr = HEAP_HI_ADDR;
          default: addr = $urandom_range(HEAP_HI_ADDR, HEAP_LO_ADDR);
        endcase
        r = build_request(4'($urandom_range(OP_IMAGE, OP_LB)), addr);
      end else if (pick < 95) begin
        case ($urandom_range(3))
          0: r = build_request(4'($urandom_range(OP_IMAGE, OP_LB)),
                               {1'b1, 31'($urandom())});
          1: r = build_request(4'($urandom_range(OP_IMAGE, OP_SB)),
                               $urandom_range(STORE_LO_ADDR - 1));
          2: r = build_request(4'($urandom_range(OP_IMAGE, OP_LB)),
                               $urandom_range(HEAP_LO_ADDR - 1, VR_HI_ADDR + 1));
          default: r = build_request(4'($urandom_range(OP_IMAGE, OP_LB)),
                                     $urandom_range(32'h7FFF_FFFF, HEAP_HI_ADDR + 1));
        endcase
      end else begin
        r = build_request(4'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO)), $urandom());
      end
      issue_access(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle_pct   = 8;
    out_stall_pct = 82;
    test_memory_access();
    test_image_writes();
    test_console_reads();
    test_virtual_routines();
    test_heap_window();
    test_illegal_addresses();
    test_random_mix(240);

    in_idle_pct   = 82;
    out_stall_pct = 8;
    test_random_mix(245);

    in_idle_pct   = 0;
    out_stall_pct = 0;
    test_random_mix(240);

    // Drain outstanding responses, then watch for strays
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0 && expected_rsp_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/vls_pkg.sv
rtl/core/vls_ram.sv
rtl/core/vls_decode.sv
rtl/core/vls_mem_port.sv
rtl/core/vm_load_store_unit.sv
rtl/core/vls_checker.sv
tb/vm_load_store_unit_tb.sv
